### sv/power_buffer_current_limiter_top_assert.svh
// assertion macros for the power buffer current limiter checker
// no dependencies; included by the checker file
`ifndef POWER_BUFFER_CURRENT_LIMITER_TOP_ASSERT_SVH
`define POWER_BUFFER_CURRENT_LIMITER_TOP_ASSERT_SVH

// clocked check, switched off while reset is held
`define PBCL_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("power buffer limiter check failed");

// clocked check that also covers the reset cycles
`define PBCL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("power buffer limiter check failed");

`endif

### sv/pbcl_pkg.sv
// shared widths, register codes and lane control type of the current limiter
// no dependencies
package pbcl_pkg;

    // item geometry
    localparam int NUM_LANES  = 8;
    localparam int HALF_LANES = NUM_LANES / 2;
    localparam int CUR_W      = 16;
    localparam int LEVEL_W    = 8;
    localparam int LIMIT_W    = 16;

    // datapath widths
    localparam int WM_W   = 20;   // current times 9 at most
    localparam int BSQ_W  = 16;   // b squared
    localparam int L2_W   = 32;   // L squared
    localparam int PROD_W = 37;   // signed weighted numerator
    localparam int NUM_W  = 35;   // numerator magnitude
    localparam int DEN_W  = 35;   // 5 * L squared
    localparam int QUOT_W = 16;

    // divider pipeline: quotient bits settled per stage
    localparam int DIV_STAGE_BITS = 4;
    localparam int DIV_STAGES     = QUOT_W / DIV_STAGE_BITS;
    // prep stage, numerator stage, then the divider stages
    localparam int NUM_STAGES     = DIV_STAGES + 2;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_POWER_LIMIT      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BUFFER_THRESHOLD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CLIMB_MODE       = 2'd2;

    localparam logic [LIMIT_W-1:0] NO_LIMIT         = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET  = 8'd60;

    // saturation bounds
    localparam logic [CUR_W-1:0]  SAT_MAX     = 16'h7FFF;
    localparam logic [CUR_W-1:0]  SAT_MIN     = 16'h8000;
    localparam logic [QUOT_W-1:0] NEG_MAG_MAX = 16'd32768;
    localparam logic [QUOT_W-1:0] POS_MAG_MAX = 16'd32767;

    typedef logic signed [CUR_W-1:0] cur_t;
    typedef logic signed [WM_W-1:0]  wm_t;

    // load strobes handed from the pipeline control to each lane
    typedef struct packed {
        logic                  load_num;
        logic [DIV_STAGES-1:0] load_div;
    } lane_ctl_t;

endpackage

### sv/power_buffer_current_limiter_top.sv
// top level of the power buffer current limiter: config registers, pipeline control,
// prep stage, eight lanes and the output register; depends on pbcl_pkg, pbcl_prep, pbcl_lane
//
// Usage
//   Input channel s_*: eight signed 16 bit current commands and the 8 bit buffer level.
//   Output channel m_*: eight limited, saturated currents and the scaling flag.
//   Both channels use valid/ready; an item moves on the edge where both are high.
//   Config: cfg_we writes cfg_wdata to register cfg_index (0 power limit, 1 buffer
//   threshold, 2 climb mode) on that edge; write only while the block holds no item.
// Timing
//   An accepted item passes the prep, numerator and divider stages and the output register.
//   One item per cycle unless stalled: every lane carries a four stage restoring divider
//   settling four quotient bits per stage, so the divider never blocks the front.
// Reset
//   aresetn low empties the pipeline and the output register and loads power limit
//   65535 (no limiting), threshold 60 and climb mode off.
// Stall
//   When m_ready is low the held result stays put; earlier stages keep filling empty
//   slots, and s_ready drops only once every stage holds an item.
module power_buffer_current_limiter_top
    import pbcl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CUR_W-1:0]      s_cur0,
    input  logic [CUR_W-1:0]      s_cur1,
    input  logic [CUR_W-1:0]      s_cur2,
    input  logic [CUR_W-1:0]      s_cur3,
    input  logic [CUR_W-1:0]      s_cur4,
    input  logic [CUR_W-1:0]      s_cur5,
    input  logic [CUR_W-1:0]      s_cur6,
    input  logic [CUR_W-1:0]      s_cur7,
    input  logic [LEVEL_W-1:0]    s_buffer_level,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CUR_W-1:0]      m_lim0,
    output logic [CUR_W-1:0]      m_lim1,
    output logic [CUR_W-1:0]      m_lim2,
    output logic [CUR_W-1:0]      m_lim3,
    output logic [CUR_W-1:0]      m_lim4,
    output logic [CUR_W-1:0]      m_lim5,
    output logic [CUR_W-1:0]      m_lim6,
    output logic [CUR_W-1:0]      m_lim7,
    output logic                  m_scaling_active,
    // configuration
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    logic [LIMIT_W-1:0]       power_limit_reg;
    logic [LEVEL_W-1:0]       buffer_threshold_reg;
    logic                     climb_mode_reg;

    logic [NUM_STAGES-1:0]    v_reg;
    logic [NUM_STAGES:0]      move;
    logic                     out_free;
    logic                     m_valid_reg;
    cur_t [NUM_LANES-1:0]     m_lim_reg;
    logic                     m_scaling_reg;
    logic [NUM_STAGES-1:1]    scl_reg;

    cur_t [NUM_LANES-1:0]     cur;
    wm_t  [NUM_LANES-1:0]     wm;
    logic [BSQ_W-1:0]         bsq;
    logic [L2_W-1:0]          l2;
    logic                     prep_scale;
    logic [DEN_W-1:0]         den;
    cur_t [NUM_LANES-1:0]     lane_lim;
    lane_ctl_t                lane_ctl;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_limit_reg      <= NO_LIMIT;
            buffer_threshold_reg <= THRESHOLD_RESET;
            climb_mode_reg       <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_POWER_LIMIT:      power_limit_reg      <= cfg_wdata[LIMIT_W-1:0];
                REG_BUFFER_THRESHOLD: buffer_threshold_reg <= cfg_wdata[LEVEL_W-1:0];
                REG_CLIMB_MODE:       climb_mode_reg       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // a stage moves when it is empty or the stage after it moves
    assign out_free = !m_valid_reg || m_ready;
    always_comb begin
        move[NUM_STAGES] = out_free;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            move[i] = !v_reg[i] || move[i+1];
        end
    end
    assign s_ready = move[0];

    // occupancy of each stage and of the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (move[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (move[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
            if (out_free) begin
                m_valid_reg <= v_reg[NUM_STAGES-1];
            end
        end
    end

    // scaling flag travels beside the lanes
    always_ff @(posedge aclk) begin
        if (move[1]) begin
            scl_reg[1] <= prep_scale;
        end
        for (int i = 2; i < NUM_STAGES; i++) begin
            if (move[i]) begin
                scl_reg[i] <= scl_reg[i-1];
            end
        end
    end

    // input item gathered into a lane array
    assign cur = {s_cur7, s_cur6, s_cur5, s_cur4, s_cur3, s_cur2, s_cur1, s_cur0};

    pbcl_prep u_prep (
        .aclk             (aclk),
        .load             (move[0]),
        .cur              (cur),
        .buffer_level     (s_buffer_level),
        .power_limit      (power_limit_reg),
        .buffer_threshold (buffer_threshold_reg),
        .climb_mode       (climb_mode_reg),
        .wm_reg           (wm),
        .bsq_reg          (bsq),
        .l2_reg           (l2),
        .scale_reg        (prep_scale)
    );

    // shared divisor, five times L squared
    assign den = (DEN_W'(l2) << 2) + DEN_W'(l2);

    // lane load strobes
    always_comb begin
        lane_ctl.load_num = move[1];
        for (int j = 0; j < DIV_STAGES; j++) begin
            lane_ctl.load_div[j] = move[j+2];
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        pbcl_lane u_lane (
            .aclk (aclk),
            .ctl  (lane_ctl),
            .wm   (wm[k]),
            .bsq  (bsq),
            .den  (den),
            .lim  (lane_lim[k])
        );
    end

    // merge: lane results and flag into the output register
    always_ff @(posedge aclk) begin
        if (out_free && v_reg[NUM_STAGES-1]) begin
            m_lim_reg     <= lane_lim;
            m_scaling_reg <= scl_reg[NUM_STAGES-1];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_lim0           = m_lim_reg[0];
    assign m_lim1           = m_lim_reg[1];
    assign m_lim2           = m_lim_reg[2];
    assign m_lim3           = m_lim_reg[3];
    assign m_lim4           = m_lim_reg[4];
    assign m_lim5           = m_lim_reg[5];
    assign m_lim6           = m_lim_reg[6];
    assign m_lim7           = m_lim_reg[7];
    assign m_scaling_active = m_scaling_reg;

endmodule

### sv/pbcl_prep.sv
// front stage: routes currents to lanes, applies distribution weights, squares b and L
// depends on pbcl_pkg
module pbcl_prep
    import pbcl_pkg::*;
(
    input  logic                         aclk,
    input  logic                         load,
    input  cur_t   [NUM_LANES-1:0]       cur,
    input  logic   [LEVEL_W-1:0]         buffer_level,
    input  logic   [LIMIT_W-1:0]         power_limit,
    input  logic   [LEVEL_W-1:0]         buffer_threshold,
    input  logic                         climb_mode,
    output wm_t    [NUM_LANES-1:0]       wm_reg,
    output logic   [BSQ_W-1:0]           bsq_reg,
    output logic   [L2_W-1:0]            l2_reg,
    output logic                         scale_reg
);

    typedef enum logic [1:0] {
        MUL_ONE,
        MUL_FIVE,
        MUL_NINE
    } mul_sel_t;

    // weight by a small constant with shifts and one add
    function automatic wm_t weight_mul(input cur_t x, input mul_sel_t sel);
        wm_t ext;
        wm_t res;
        ext = {{(WM_W-CUR_W){x[CUR_W-1]}}, x};
        case (sel)
            MUL_ONE:  res = ext;
            MUL_FIVE: res = (ext <<< 2) + ext;
            MUL_NINE: res = (ext <<< 3) + ext;
            default:  res = ext;
        endcase
        return res;
    endfunction

    logic                      limit_on;
    logic                      scale;
    logic                      climb;
    wm_t  [NUM_LANES-1:0]      wm_next;
    logic [BSQ_W-1:0]          bsq_next;
    logic [L2_W-1:0]           l2_next;

    // mode decode; without limiting every lane gets weight five over five
    assign limit_on = (power_limit != NO_LIMIT);
    assign scale    = limit_on && (buffer_level < buffer_threshold);
    assign climb    = limit_on && climb_mode;

    // lane routing: in climb mode the rear lanes reuse the front currents
    always_comb begin
        for (int i = 0; i < HALF_LANES; i++) begin
            if (climb) begin
                wm_next[i]              = weight_mul(cur[i], MUL_NINE);
                wm_next[i + HALF_LANES] = weight_mul(cur[i], MUL_ONE);
            end else begin
                wm_next[i]              = weight_mul(cur[i], MUL_FIVE);
                wm_next[i + HALF_LANES] = weight_mul(cur[i + HALF_LANES], MUL_FIVE);
            end
        end
    end

    // squares, unity when scaling is off
    always_comb begin
        bsq_next = scale ? BSQ_W'({8'd0, buffer_level} * {8'd0, buffer_level})
                         : BSQ_W'(1);
        l2_next  = scale ? L2_W'({16'd0, power_limit} * {16'd0, power_limit})
                         : L2_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            wm_reg    <= wm_next;
            bsq_reg   <= bsq_next;
            l2_reg    <= l2_next;
            scale_reg <= scale;
        end
    end

endmodule

### sv/pbcl_lane.sv
// one lane: numerator product, pipelined restoring divider and int16 saturation
// depends on pbcl_pkg
module pbcl_lane
    import pbcl_pkg::*;
(
    input  logic              aclk,
    input  lane_ctl_t         ctl,
    input  wm_t               wm,
    input  logic [BSQ_W-1:0]  bsq,
    input  logic [DEN_W-1:0]  den,
    output cur_t              lim
);

    localparam int WIDE_W = DEN_W + QUOT_W;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_abs;
    logic [NUM_W-1:0]         mag_reg;
    logic [DEN_W-1:0]         nden_reg;
    logic                     nneg_reg;
    logic                     nzero_reg;
    logic                     ovf_first;

    logic [NUM_W-1:0]  rem_reg  [DIV_STAGES];
    logic [QUOT_W-1:0] q_reg    [DIV_STAGES];
    logic [DEN_W-1:0]  den_reg  [DIV_STAGES];
    logic              neg_reg  [DIV_STAGES];
    logic              zero_reg [DIV_STAGES];
    logic              ovf_reg  [DIV_STAGES];

    // signed numerator and its magnitude
    assign prod     = $signed(wm) * $signed({1'b0, bsq});
    assign prod_abs = prod[PROD_W-1] ? -prod : prod;

    always_ff @(posedge aclk) begin
        if (ctl.load_num) begin
            mag_reg   <= prod_abs[NUM_W-1:0];
            nneg_reg  <= prod[PROD_W-1];
            nzero_reg <= (prod == '0);
            nden_reg  <= den;
        end
    end

    // quotient beyond sixteen bits means saturation; a zero divisor lands here too
    assign ovf_first = ({{QUOT_W{1'b0}}, mag_reg} >= {nden_reg, {QUOT_W{1'b0}}});

    // divider stages, most significant quotient bits first
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        logic [NUM_W-1:0]  rem_in;
        logic [QUOT_W-1:0] q_in;
        logic [DEN_W-1:0]  den_in;
        logic              neg_in;
        logic              zero_in;
        logic              ovf_in;
        logic [NUM_W-1:0]  rem_out;
        logic [QUOT_W-1:0] q_out;

        if (j == 0) begin : g_head
            assign rem_in  = mag_reg;
            assign q_in    = '0;
            assign den_in  = nden_reg;
            assign neg_in  = nneg_reg;
            assign zero_in = nzero_reg;
            assign ovf_in  = ovf_first;
        end else begin : g_body
            assign rem_in  = rem_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign neg_in  = neg_reg[j-1];
            assign zero_in = zero_reg[j-1];
            assign ovf_in  = ovf_reg[j-1];
        end

        // compare and subtract for each bit of this stage
        always_comb begin
            logic [WIDE_W-1:0] trial;
            int                sh;
            rem_out = rem_in;
            q_out   = q_in;
            for (int t = 0; t < DIV_STAGE_BITS; t++) begin
                sh    = QUOT_W - 1 - j * DIV_STAGE_BITS - t;
                trial = {{QUOT_W{1'b0}}, den_in} << sh;
                if ({{QUOT_W{1'b0}}, rem_out} >= trial) begin
                    rem_out = rem_out - trial[NUM_W-1:0];
                    q_out   = {q_out[QUOT_W-2:0], 1'b1};
                end else begin
                    q_out   = {q_out[QUOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.load_div[j]) begin
                rem_reg[j]  <= rem_out;
                q_reg[j]    <= q_out;
                den_reg[j]  <= den_in;
                neg_reg[j]  <= neg_in;
                zero_reg[j] <= zero_in;
                ovf_reg[j]  <= ovf_in;
            end
        end
    end

    // sign and saturation on the truncated quotient
    always_comb begin
        logic [QUOT_W-1:0] q;
        q = q_reg[DIV_STAGES-1];
        if (zero_reg[DIV_STAGES-1]) begin
            lim = '0;
        end else if (ovf_reg[DIV_STAGES-1]) begin
            lim = neg_reg[DIV_STAGES-1] ? SAT_MIN : SAT_MAX;
        end else if (neg_reg[DIV_STAGES-1]) begin
            lim = (q > NEG_MAG_MAX) ? SAT_MIN : cur_t'(QUOT_W'(0) - q);
        end else begin
            lim = (q > POS_MAG_MAX) ? SAT_MAX : cur_t'(q);
        end
    end

endmodule

### sv/pbcl_checker.sv
// port level checks of the current limiter, bound to the top level
// depends on power_buffer_current_limiter_top_assert.svh and the top level
`include "power_buffer_current_limiter_top_assert.svh"

module pbcl_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_lim0,
    input  logic [15:0] m_lim1,
    input  logic [15:0] m_lim2,
    input  logic [15:0] m_lim3,
    input  logic [15:0] m_lim4,
    input  logic [15:0] m_lim5,
    input  logic [15:0] m_lim6,
    input  logic [15:0] m_lim7,
    input  logic        m_scaling_active
);

    logic [128:0] out_bus;

    // whole result item as one word
    assign out_bus = {m_scaling_active, m_lim7, m_lim6, m_lim5, m_lim4,
                      m_lim3, m_lim2, m_lim1, m_lim0};

    // a stalled result item holds
    `PBCL_ASSERT(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(out_bus))

    // reset leaves no result item pending
    `PBCL_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // a free output slot lets the whole pipeline move, so input is taken
    `PBCL_ASSERT(a_ready_when_free, aclk, aresetn, !m_valid || m_ready |-> s_ready)

    // an input item offered while the output item is being taken cannot be refused
    `PBCL_ASSERT(a_take_on_drain, aclk, aresetn, s_valid && m_valid && m_ready |-> s_ready)

endmodule

bind power_buffer_current_limiter_top pbcl_checker u_pbcl_checker (.*);

### tb/sv/power_buffer_current_limiter_top_test.sv
// self-checking test of power_buffer_current_limiter_top: random and directed items
// with random idling on both channels; depends on pbcl_pkg and the block's rtl
module power_buffer_current_limiter_top_test
    import pbcl_pkg::*;
;

    // lane weights: climb front 9/5, climb rear 1/5, normal 5/5
    localparam longint FRONT_MUL = 9;
    localparam longint REAR_MUL  = 1;
    localparam longint NORMAL_MUL = 5;
    localparam longint SHARE_DEN = 5;
    localparam longint INT16_MAX = 32767;
    localparam longint INT16_MIN = -32768;

    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 75;
    localparam int DRAIN_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 200000;

    // lanes 7..0: -1, 1, min, max, -1000, 1000, -100, 100
    localparam logic [NUM_LANES-1:0][CUR_W-1:0] MIXED_LANES = {
        16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hFC18, 16'h03E8, 16'hFF9C, 16'h0064
    };

    typedef struct packed {
        logic [NUM_LANES-1:0][CUR_W-1:0] cur;
        logic [LEVEL_W-1:0]              level;
    } command_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][CUR_W-1:0] lim;
        logic                            scaling;
    } limited_t;

    // register mirror, limit predictor and store of expected limited items
    class limit_scoreboard;
        logic [LIMIT_W-1:0] power_limit;
        logic [LEVEL_W-1:0] threshold;
        logic               climb;
        limited_t           expected_limits[$];
        int                 failures;

        function new();
            power_limit = NO_LIMIT;
            threshold   = THRESHOLD_RESET;
            climb       = 1'b0;
            failures    = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_POWER_LIMIT:      power_limit = value[LIMIT_W-1:0];
                REG_BUFFER_THRESHOLD: threshold = value[LEVEL_W-1:0];
                REG_CLIMB_MODE:       climb = value[0];
                default: ;
            endcase
        endfunction

        // exact quotient truncated toward zero, then clamped to int16
        function logic [CUR_W-1:0] lane_value(longint w, longint mul, longint bsq,
                                              longint den);
            longint prod;
            longint q;
            prod = w * mul * bsq;
            if (prod == 0) return '0;
            if (den == 0) q = (prod > 0) ? INT16_MAX : INT16_MIN;
            else q = prod / den;
            if (q > INT16_MAX) q = INT16_MAX;
            if (q < INT16_MIN) q = INT16_MIN;
            return q[CUR_W-1:0];
        endfunction

        function void note_command(command_t c);
            limited_t r;
            longint   w [NUM_LANES];
            longint   bsq;
            longint   den;
            bit       scale;
            for (int i = 0; i < NUM_LANES; i++) w[i] = longint'($signed(c.cur[i]));
            r = '0;
            if (power_limit == NO_LIMIT) begin
                // pass-through, climb mode has no effect
                r.lim = c.cur;
            end else begin
                scale = c.level < threshold;
                bsq = scale ? longint'(c.level) * longint'(c.level) : 1;
                den = scale ? SHARE_DEN * longint'(power_limit) * longint'(power_limit)
                            : SHARE_DEN;
                for (int i = 0; i < HALF_LANES; i++) begin
                    if (climb) begin
                        r.lim[i] = lane_value(w[i], FRONT_MUL, bsq, den);
                        r.lim[i+HALF_LANES] = lane_value(w[i], REAR_MUL, bsq, den);
                    end else begin
                        r.lim[i] = lane_value(w[i], NORMAL_MUL, bsq, den);
                        r.lim[i+HALF_LANES] = lane_value(w[i+HALF_LANES], NORMAL_MUL, bsq, den);
                    end
                end
                r.scaling = scale;
            end
            expected_limits.push_back(r);
        endfunction

        function void check_result(limited_t got);
            limited_t want;
            if (expected_limits.size() == 0) begin
                failures++;
                $display("%0t: unexpected item, expected none, got lim=%h scaling=%b",
                         $time, got.lim, got.scaling);
                return;
            end
            want = expected_limits.pop_front();
            for (int i = 0; i < NUM_LANES; i++) begin
                if (got.lim[i] !== want.lim[i]) begin
                    failures++;
                    $display("%0t: lim%0d expected %0d got %0d", $time, i,
                             $signed(want.lim[i]), $signed(got.lim[i]));
                end
            end
            if (got.scaling !== want.scaling) begin
                failures++;
                $display("%0t: scaling_active expected %b got %b", $time,
                         want.scaling, got.scaling);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    command_t             drive_cmd;
    logic                 m_valid;
    logic                 m_ready;
    logic [CUR_W-1:0]     m_lim0, m_lim1, m_lim2, m_lim3;
    logic [CUR_W-1:0]     m_lim4, m_lim5, m_lim6, m_lim7;
    logic                 m_scaling_active;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    limit_scoreboard board;
    int send_calm;
    int take_calm;
    int cycles;

    power_buffer_current_limiter_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cur0           (drive_cmd.cur[0]),
        .s_cur1           (drive_cmd.cur[1]),
        .s_cur2           (drive_cmd.cur[2]),
        .s_cur3           (drive_cmd.cur[3]),
        .s_cur4           (drive_cmd.cur[4]),
        .s_cur5           (drive_cmd.cur[5]),
        .s_cur6           (drive_cmd.cur[6]),
        .s_cur7           (drive_cmd.cur[7]),
        .s_buffer_level   (drive_cmd.level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_lim0           (m_lim0),
        .m_lim1           (m_lim1),
        .m_lim2           (m_lim2),
        .m_lim3           (m_lim3),
        .m_lim4           (m_lim4),
        .m_lim5           (m_lim5),
        .m_lim6           (m_lim6),
        .m_lim7           (m_lim7),
        .m_scaling_active (m_scaling_active),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // idle cycles per item, with occasional runs of back-to-back items
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // present one item and hold it until accepted; called at a rising edge
    task automatic send_command(input command_t c);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        drive_cmd <= c;
        @(negedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
            @(negedge aclk);
        end
        @(posedge aclk);
        board.note_command(c);
    endtask

    task automatic send_lanes(input logic [NUM_LANES-1:0][CUR_W-1:0] lanes,
                              input logic [LEVEL_W-1:0] lvl);
        command_t c;
        c.cur   = lanes;
        c.level = lvl;
        send_command(c);
    endtask

    // wait until every expected item is out and the pipeline has drained
    task automatic settle();
        s_valid <= 1'b0;
        while (board.expected_limits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.set_reg(idx, value);
    endtask

    // unused upper bits of the narrow registers carry random junk
    task automatic apply_setting(input logic [LIMIT_W-1:0] limit, input logic [LEVEL_W-1:0] thr,
                                 input logic climb);
        program_reg(REG_POWER_LIMIT, limit);
        program_reg(REG_BUFFER_THRESHOLD, {8'($urandom), thr});
        program_reg(REG_CLIMB_MODE, {15'($urandom), climb});
    endtask

    // cycle limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, check each accepted item
    initial begin : result_side
        int       stall;
        limited_t got;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_gap(take_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(negedge aclk);
            while (!m_valid) begin
                @(posedge aclk);
                @(negedge aclk);
            end
            got.lim     = {m_lim7, m_lim6, m_lim5, m_lim4, m_lim3, m_lim2, m_lim1, m_lim0};
            got.scaling = m_scaling_active;
            board.check_result(got);
            @(posedge aclk);
        end
    end

    // stimulus
    initial begin : stimulus
        command_t           c;
        logic [LIMIT_W-1:0] limit_v;
        logic [LEVEL_W-1:0] thr_v;
        board     = new();
        send_calm = 0;
        take_calm = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        drive_cmd <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_POWER_LIMIT;
        cfg_wdata <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: pass-through
        send_lanes({NUM_LANES{16'h7FFF}}, 8'd0);
        send_lanes({NUM_LANES{16'h8000}}, 8'd255);
        send_lanes(MIXED_LANES, 8'd59);
        send_lanes('0, 8'd0);

        // normal mode, levels around the threshold, all-zero commands
        settle();
        apply_setting(16'd60, 8'd60, 1'b0);
        send_lanes('0, 8'd0);
        send_lanes(MIXED_LANES, 8'd0);
        send_lanes(MIXED_LANES, 8'd30);
        send_lanes(MIXED_LANES, 8'd59);
        send_lanes(MIXED_LANES, 8'd60);
        send_lanes(MIXED_LANES, 8'd255);

        // climb mode, saturation at both ends
        settle();
        apply_setting(16'd60, 8'd255, 1'b1);
        send_lanes(MIXED_LANES, 8'd45);
        send_lanes({NUM_LANES{16'h7FFF}}, 8'd254);
        send_lanes({NUM_LANES{16'h8000}}, 8'd254);
        send_lanes('0, 8'd100);
        send_lanes(MIXED_LANES, 8'd255);

        // zero power limit while scaling
        settle();
        apply_setting(16'd0, 8'd255, 1'b0);
        send_lanes(MIXED_LANES, 8'd10);
        send_lanes(MIXED_LANES, 8'd0);
        send_lanes('0, 8'd200);

        // zero threshold: scaling never applies
        settle();
        apply_setting(16'd0, 8'd0, 1'b1);
        send_lanes(MIXED_LANES, 8'd0);
        send_lanes({NUM_LANES{16'h8000}}, 8'd0);

        // no limiting overrides climb mode
        settle();
        apply_setting(NO_LIMIT, 8'd255, 1'b1);
        send_lanes(MIXED_LANES, 8'd0);
        send_lanes({NUM_LANES{16'h8000}}, 8'd3);

        // random phases, each with its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            case ($urandom_range(0, 7))
                0:       limit_v = NO_LIMIT;
                1:       limit_v = '0;
                2:       limit_v = 16'd1;
                3:       limit_v = 16'd65534;
                4, 5:    limit_v = LIMIT_W'($urandom_range(1, 300));
                default: limit_v = LIMIT_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       thr_v = '0;
                1:       thr_v = 8'd255;
                default: thr_v = LEVEL_W'($urandom);
            endcase
            apply_setting(limit_v, thr_v, 1'($urandom_range(0, 1)));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                for (int i = 0; i < NUM_LANES; i++) begin
                    case ($urandom_range(0, 7))
                        0:       c.cur[i] = SAT_MAX;
                        1:       c.cur[i] = SAT_MIN;
                        2:       c.cur[i] = '0;
                        3, 4:    c.cur[i] = CUR_W'($urandom);
                        default: c.cur[i] = CUR_W'($urandom_range(0, 2000) - 1000);
                    endcase
                end
                if ($urandom_range(0, 19) == 0) c.cur = '0;
                // levels: anywhere, next to the threshold, or up to the limit
                case ($urandom_range(0, 3))
                    0:       c.level = LEVEL_W'($urandom);
                    1:       c.level = board.threshold + LEVEL_W'($urandom_range(0, 2)) - 8'd1;
                    default: c.level = LEVEL_W'($urandom_range(0,
                                 (board.power_limit < 255) ? board.power_limit : 255));
                endcase
                send_command(c);
            end
        end

        settle();
        if (board.failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
